@@ hdl/irep_pkg.sv @@
// ============================================================================
// irep_pkg - shared types and constants of the region erase planner
// Field widths, sector geometry, result codes and the transaction formats
// that pass between the front end, the queue and the erase sequencer.
// ============================================================================
`default_nettype none

package irep_pkg;

    localparam int ADDR_W        = 32;
    localparam int WORDS_W       = 21;
    localparam int COUNT_W       = 16;
    localparam int REGION_W      = 3;
    localparam int SECS_W        = 7;
    localparam int CMD_W         = 6;
    localparam int BOUNDS_W      = 64;
    localparam int PADDR_W       = 6;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 48;

    localparam int REGIONS       = 5;
    localparam int SECTOR_SHIFT  = 14;
    localparam int SECTOR_BYTES  = 1 << SECTOR_SHIFT;
    localparam int CHUNK_SECTORS = 64;
    localparam int MAX_CMDS      = 63;

    localparam logic [REGION_W-1:0] LAST_REGION = REGION_W'(REGIONS - 1);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef logic [REGIONS-1:0][BOUNDS_W-1:0] bounds_vec_t;

    typedef enum logic [1:0] {
        ST_ERASE   = 2'd0,
        ST_DONE    = 2'd1,
        ST_BAD     = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_BAD   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_NEED,
        B_EMIT,
        B_DONE
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [REGIONS-1:0] hit;
        logic [ADDR_W-1:0]  start_addr;
        logic [WORDS_W-1:0] word_count;
    } entry_t;

    typedef struct packed {
        status_t             status;
        logic [REGION_W-1:0] region;
        logic [ADDR_W-1:0]   erase_addr;
        logic [SECS_W-1:0]   erase_sectors;
        logic                last;
    } result_t;

    function automatic logic [ADDR_W-1:0] region_start(input logic [BOUNDS_W-1:0] b);
        return b[BOUNDS_W-1:ADDR_W];
    endfunction

    function automatic logic [ADDR_W-1:0] region_end(input logic [BOUNDS_W-1:0] b);
        return b[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/incremental_region_erase_planner.sv @@
// ============================================================================
// incremental_region_erase_planner - flash region erase planner
// Turns write requests into chunked sector erase commands per region.
// ============================================================================
// A request is classified as it is accepted (bounds check, region match) and
// queued; the sequencer then takes one queued request at a time. A clear or a
// bounds error gives its single registered result when it reaches the queue
// head and the result slot is free. A write starts, walks the regions one by
// one, skipping each that misses, works out the sectors needed for each region
// that holds the start address and issues its erase commands (at most 63 per
// request), then gives the closing result; stalls on the result side hold the
// commands and the closing result. Input transactions keep being accepted while
// the queue has room.
`default_nettype none

module incremental_region_erase_planner
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [irep_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [irep_pkg::BOUNDS_W-1:0]      pwdata,
    output logic      [irep_pkg::BOUNDS_W-1:0]      prdata,
    output logic                                    pready,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [irep_pkg::S_TDATA_W-1:0]     s_tdata,  // start_addr, word_count
    input  wire logic                               s_tuser,  // kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [irep_pkg::M_TDATA_W-1:0]     m_tdata,  // region, erase_addr, erase_sectors
    output logic      [1:0]                         m_tuser,  // status
    output logic                                    m_tlast
);

    irep_pkg::bounds_vec_t bounds;
    irep_pkg::entry_t      push_entry;
    irep_pkg::entry_t      q_head;
    logic                  push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;

    irep_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bounds  (bounds)
    );

    irep_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .bounds     (bounds),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    irep_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    irep_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .bounds   (bounds),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ hdl/irep_cfg.sv @@
// ============================================================================
// irep_cfg - region bounds register file
// APB-style slave holding one 64-bit bounds register per region.
// ============================================================================
`default_nettype none

module irep_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [irep_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [irep_pkg::BOUNDS_W-1:0]    pwdata,
    output logic      [irep_pkg::BOUNDS_W-1:0]    prdata,
    output logic                                  pready,
    output irep_pkg::bounds_vec_t                 bounds
);

    irep_pkg::bounds_vec_t                 bounds_reg;
    logic [irep_pkg::REGION_W-1:0]         idx;
    logic                                  idx_ok;

    assign idx    = paddr[irep_pkg::PADDR_W-1:3];
    assign idx_ok = idx < irep_pkg::REGION_W'(irep_pkg::REGIONS);
    assign pready = 1'b1;
    assign bounds = bounds_reg;

    always_comb
    begin
        prdata = '0;
        if (idx_ok)
        begin
            prdata = bounds_reg[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg <= '0;
        end
        else if (psel && penable && pwrite && idx_ok)
        begin
            bounds_reg[idx] <= pwdata;
        end
    end

endmodule

`default_nettype wire

@@ hdl/irep_front.sv @@
// ============================================================================
// irep_front - request classifier
// Accepts input transactions, checks all region bounds, marks the regions
// that hold the start address and queues the classified request.
// ============================================================================
`default_nettype none

module irep_front
(
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [irep_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic                                 s_tuser,
    input  wire irep_pkg::bounds_vec_t                bounds,
    input  wire logic                                 q_full,
    output logic                                      push,
    output irep_pkg::entry_t                          push_entry
);

    logic [irep_pkg::ADDR_W-1:0]  addr;
    logic [irep_pkg::WORDS_W-1:0] words;
    logic [irep_pkg::REGIONS-1:0] region_ok;
    logic [irep_pkg::REGIONS-1:0] hit;

    assign addr     = s_tdata[irep_pkg::ADDR_W-1:0];
    assign words    = s_tdata[irep_pkg::ADDR_W +: irep_pkg::WORDS_W];
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        logic [irep_pkg::ADDR_W-1:0] rs;
        logic [irep_pkg::ADDR_W-1:0] re;
        logic [irep_pkg::ADDR_W-1:0] len;
        for (int r = 0; r < irep_pkg::REGIONS; r++)
        begin
            rs  = irep_pkg::region_start(bounds[r]);
            re  = irep_pkg::region_end(bounds[r]);
            len = re - rs + irep_pkg::ADDR_W'(1);
            region_ok[r] = (rs <= re) &&
                ((len[irep_pkg::SECTOR_SHIFT-1:0] == '0) || (rs == re));
            hit[r] = (addr >= rs) && (addr < re);
        end
    end

    always_comb
    begin
        push_entry.hit        = hit;
        push_entry.start_addr = addr;
        push_entry.word_count = words;
        if (s_tuser == irep_pkg::KIND_CLEAR)
        begin
            push_entry.op = irep_pkg::OP_CLEAR;
        end
        else if (!(&region_ok))
        begin
            push_entry.op = irep_pkg::OP_BAD;
        end
        else
        begin
            push_entry.op = irep_pkg::OP_WRITE;
        end
    end

endmodule

`default_nettype wire

@@ hdl/irep_fifo.sv @@
// ============================================================================
// irep_fifo - request queue
// Short first-in first-out queue of classified requests between the front
// end and the erase sequencer.
// ============================================================================
`default_nettype none

module irep_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire irep_pkg::entry_t  push_entry,
    input  wire logic              pop,
    output irep_pkg::entry_t       head,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    irep_pkg::entry_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = cnt_reg == CNT_W'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/irep_back.sv @@
// ============================================================================
// irep_back - erase sequencer
// Walks the regions of one queued request, works out the sectors needed,
// issues erase commands in chunks and keeps the erased-sector counts.
// ============================================================================
`default_nettype none

module irep_back
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire irep_pkg::bounds_vec_t                bounds,
    input  wire irep_pkg::entry_t                     q_head,
    input  wire logic                                 q_empty,
    output logic                                      q_pop,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [irep_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic      [1:0]                           m_tuser,
    output logic                                      m_tlast
);

    localparam int NBYTES_W = irep_pkg::ADDR_W + 1;
    localparam int SUM_W    = NBYTES_W + 1;
    localparam int NEED_W   = SUM_W - irep_pkg::SECTOR_SHIFT;
    localparam int PAD_W    = irep_pkg::M_TDATA_W - irep_pkg::REGION_W
                              - irep_pkg::ADDR_W - irep_pkg::SECS_W;

    irep_pkg::back_state_t               state_reg;
    irep_pkg::back_state_t               state_next;
    irep_pkg::entry_t                    item_reg;
    logic [irep_pkg::REGION_W-1:0]       r_reg;
    logic [irep_pkg::CMD_W-1:0]          n_reg;
    logic [irep_pkg::COUNT_W-1:0]        need_reg;
    logic [irep_pkg::COUNT_W-1:0]        erased_reg [irep_pkg::REGIONS];
    logic                                m_valid_reg;
    irep_pkg::result_t                   m_res_reg;

    logic                                slot_free;
    logic [irep_pkg::ADDR_W-1:0]         rs;
    logic [irep_pkg::COUNT_W-1:0]        erased;
    logic [NBYTES_W-1:0]                 nbytes;
    logic [SUM_W-1:0]                    rounded;
    logic [NEED_W-1:0]                   need_wide;
    logic [irep_pkg::COUNT_W-1:0]        need_sat;
    logic [irep_pkg::COUNT_W-1:0]        delta;
    logic [irep_pkg::SECS_W-1:0]         chunk;
    logic [irep_pkg::ADDR_W-1:0]         erase_addr;
    logic                                more;
    logic                                is_last_region;

    logic                                load_item;
    logic                                need_load;
    logic                                r_inc;
    logic                                cnt_inc;
    logic                                cnt_clear;
    logic                                emit;
    irep_pkg::result_t                   emit_res;

    assign slot_free      = !m_valid_reg || m_tready;
    assign rs             = irep_pkg::region_start(bounds[r_reg]);
    assign erased         = erased_reg[r_reg];
    assign is_last_region = r_reg == irep_pkg::LAST_REGION;

    assign nbytes    = NBYTES_W'(item_reg.start_addr - rs)
                       + NBYTES_W'({item_reg.word_count, 2'b00});
    assign rounded   = SUM_W'(nbytes) + SUM_W'(irep_pkg::SECTOR_BYTES - 1);
    assign need_wide = rounded[SUM_W-1:irep_pkg::SECTOR_SHIFT];
    assign need_sat  = (need_wide > NEED_W'({irep_pkg::COUNT_W{1'b1}}))
                       ? {irep_pkg::COUNT_W{1'b1}}
                       : need_wide[irep_pkg::COUNT_W-1:0];

    assign more       = (need_reg > erased) && (n_reg < irep_pkg::CMD_W'(irep_pkg::MAX_CMDS));
    assign delta      = need_reg - erased;
    assign chunk      = (delta > irep_pkg::COUNT_W'(irep_pkg::CHUNK_SECTORS))
                        ? irep_pkg::SECS_W'(irep_pkg::CHUNK_SECTORS)
                        : delta[irep_pkg::SECS_W-1:0];
    assign erase_addr = rs + irep_pkg::ADDR_W'({erased, {irep_pkg::SECTOR_SHIFT{1'b0}}});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            irep_pkg::B_IDLE:
            begin
                if (!q_empty && slot_free && q_head.op == irep_pkg::OP_WRITE)
                begin
                    state_next = irep_pkg::B_NEED;
                end
            end
            irep_pkg::B_NEED:
            begin
                if (item_reg.hit[r_reg])
                begin
                    state_next = irep_pkg::B_EMIT;
                end
                else if (is_last_region)
                begin
                    state_next = irep_pkg::B_DONE;
                end
            end
            irep_pkg::B_EMIT:
            begin
                if (!more)
                begin
                    state_next = is_last_region ? irep_pkg::B_DONE : irep_pkg::B_NEED;
                end
            end
            irep_pkg::B_DONE:
            begin
                if (slot_free)
                begin
                    state_next = irep_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = irep_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        load_item = 1'b0;
        need_load = 1'b0;
        r_inc     = 1'b0;
        cnt_inc   = 1'b0;
        cnt_clear = 1'b0;
        emit      = 1'b0;
        emit_res  = '0;
        case (state_reg)
            irep_pkg::B_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q_head.op)
                        irep_pkg::OP_CLEAR:
                        begin
                            cnt_clear       = 1'b1;
                            emit            = 1'b1;
                            emit_res.status = irep_pkg::ST_CLEARED;
                            emit_res.last   = 1'b1;
                        end
                        irep_pkg::OP_BAD:
                        begin
                            emit            = 1'b1;
                            emit_res.status = irep_pkg::ST_BAD;
                            emit_res.last   = 1'b1;
                        end
                        default:
                        begin
                            load_item = 1'b1;
                        end
                    endcase
                end
            end
            irep_pkg::B_NEED:
            begin
                if (item_reg.hit[r_reg])
                begin
                    need_load = 1'b1;
                end
                else if (!is_last_region)
                begin
                    r_inc = 1'b1;
                end
            end
            irep_pkg::B_EMIT:
            begin
                if (more)
                begin
                    if (slot_free)
                    begin
                        emit                   = 1'b1;
                        cnt_inc                = 1'b1;
                        emit_res.status        = irep_pkg::ST_ERASE;
                        emit_res.region        = r_reg;
                        emit_res.erase_addr    = erase_addr;
                        emit_res.erase_sectors = chunk;
                    end
                end
                else if (!is_last_region)
                begin
                    r_inc = 1'b1;
                end
            end
            irep_pkg::B_DONE:
            begin
                if (slot_free)
                begin
                    emit            = 1'b1;
                    emit_res.status = irep_pkg::ST_DONE;
                    emit_res.last   = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= q_head;
        end
        if (need_load)
        begin
            need_reg <= need_sat;
        end
        if (emit)
        begin
            m_res_reg <= emit_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= irep_pkg::B_IDLE;
            r_reg       <= '0;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < irep_pkg::REGIONS; i++)
            begin
                erased_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_item)
            begin
                r_reg <= '0;
                n_reg <= '0;
            end
            else
            begin
                if (r_inc)
                begin
                    r_reg <= r_reg + irep_pkg::REGION_W'(1);
                end
                if (cnt_inc)
                begin
                    n_reg <= n_reg + irep_pkg::CMD_W'(1);
                end
            end
            if (cnt_clear)
            begin
                for (int i = 0; i < irep_pkg::REGIONS; i++)
                begin
                    erased_reg[i] <= '0;
                end
            end
            else if (cnt_inc)
            begin
                erased_reg[r_reg] <= erased + irep_pkg::COUNT_W'(chunk);
            end
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {{PAD_W{1'b0}}, m_res_reg.erase_sectors, m_res_reg.erase_addr,
                       m_res_reg.region};

endmodule

`default_nettype wire

@@ hdl/irep_checker.sv @@
// ============================================================================
// irep_checker - port-level checks of the erase planner
// Watches the result stream and the register port of the top level.
// ============================================================================
`default_nettype none

module irep_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               pready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [irep_pkg::M_TDATA_W-1:0]     m_tdata,
    input wire logic [1:0]                         m_tuser,
    input wire logic                               m_tlast
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result transaction changed");

    a_erase_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == irep_pkg::ST_ERASE |->
            !m_tlast && m_tdata[2:0] < 3'(irep_pkg::REGIONS) && m_tdata[41:35] != 7'd0
            && m_tdata[41:35] <= 7'(irep_pkg::CHUNK_SECTORS))
        else $error("malformed erase command");

    a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != irep_pkg::ST_ERASE |-> m_tlast && m_tdata == '0)
        else $error("status transaction not a clean closing result");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind incremental_region_erase_planner irep_checker u_irep_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/sv/erase_plan_checker.sv @@
// ============================================================================
// erase_plan_checker - result checker for the region erase planner
// Follows the register port and both streams, keeps its own region bounds
// and erased-sector counts, plans the results of every accepted request and
// compares each accepted result field by field with the oldest planned one.
// ============================================================================
`default_nettype none

module erase_plan_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic                               pready,
    input  wire logic [irep_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [irep_pkg::BOUNDS_W-1:0]      pwdata,
    input  wire logic                               s_tvalid,
    input  wire logic                               s_tready,
    input  wire logic [irep_pkg::S_TDATA_W-1:0]     s_tdata,  // start_addr, word_count
    input  wire logic                               s_tuser,  // kind
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [irep_pkg::M_TDATA_W-1:0]     m_tdata,  // region, erase_addr, erase_sectors
    input  wire logic [1:0]                         m_tuser,  // status
    input  wire logic                               m_tlast,
    output int unsigned                             fail_count,
    output int unsigned                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [irep_pkg::BOUNDS_W-1:0] bounds_copy [irep_pkg::REGIONS];
    logic [irep_pkg::COUNT_W-1:0]  erased_copy [irep_pkg::REGIONS];
    irep_pkg::result_t             planned_results [$];
    irep_pkg::result_t             head;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 100)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic irep_pkg::result_t erase_result(
        input irep_pkg::status_t st, input logic [irep_pkg::REGION_W-1:0] rg,
        input logic [irep_pkg::ADDR_W-1:0] ea,
        input logic [irep_pkg::SECS_W-1:0] n, input logic l);
        irep_pkg::result_t res;
        res.status        = st;
        res.region        = rg;
        res.erase_addr    = ea;
        res.erase_sectors = n;
        res.last          = l;
        return res;
    endfunction

    function automatic bit bounds_valid();
        logic [irep_pkg::ADDR_W-1:0] lo;
        logic [irep_pkg::ADDR_W-1:0] hi;
        logic [irep_pkg::ADDR_W-1:0] span;
        for (int r = 0; r < irep_pkg::REGIONS; r++)
        begin
            lo   = bounds_copy[r][irep_pkg::BOUNDS_W-1:irep_pkg::ADDR_W];
            hi   = bounds_copy[r][irep_pkg::ADDR_W-1:0];
            span = hi - lo + 32'd1;
            if (lo > hi)
                return 1'b0;
            if (span[irep_pkg::SECTOR_SHIFT-1:0] != '0 && lo != hi)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic plan_request(input logic kind, input logic [irep_pkg::ADDR_W-1:0] addr,
                                input logic [irep_pkg::WORDS_W-1:0] words);
        logic [irep_pkg::ADDR_W-1:0]  lo;
        logic [33:0]                  span_bytes;
        logic [33:0]                  need_raw;
        logic [irep_pkg::COUNT_W-1:0] need;
        logic [irep_pkg::COUNT_W-1:0] missing;
        logic [irep_pkg::SECS_W-1:0]  chunk;
        int                           cmds;
        cmds = 0;
        if (kind == irep_pkg::KIND_CLEAR)
        begin
            foreach (erased_copy[r])
                erased_copy[r] = '0;
            planned_results.push_back(erase_result(irep_pkg::ST_CLEARED, '0, '0, '0, 1'b1));
            return;
        end
        if (!bounds_valid())
        begin
            planned_results.push_back(erase_result(irep_pkg::ST_BAD, '0, '0, '0, 1'b1));
            return;
        end
        for (int r = 0; r < irep_pkg::REGIONS; r++)
        begin
            lo = bounds_copy[r][irep_pkg::BOUNDS_W-1:irep_pkg::ADDR_W];
            if (addr >= lo && addr < bounds_copy[r][irep_pkg::ADDR_W-1:0])
            begin
                span_bytes = {2'b00, addr - lo} + {11'b0, words, 2'b00};
                need_raw   = (span_bytes + 34'(irep_pkg::SECTOR_BYTES - 1))
                             >> irep_pkg::SECTOR_SHIFT;
                need       = (need_raw > 34'hFFFF) ? 16'hFFFF
                                                   : need_raw[irep_pkg::COUNT_W-1:0];
                while (need > erased_copy[r] && cmds < irep_pkg::MAX_CMDS)
                begin
                    missing = need - erased_copy[r];
                    chunk   = (missing > irep_pkg::COUNT_W'(irep_pkg::CHUNK_SECTORS))
                              ? irep_pkg::SECS_W'(irep_pkg::CHUNK_SECTORS)
                              : missing[irep_pkg::SECS_W-1:0];
                    planned_results.push_back(erase_result(irep_pkg::ST_ERASE,
                        irep_pkg::REGION_W'(r),
                        lo + {erased_copy[r], {irep_pkg::SECTOR_SHIFT{1'b0}}},
                        chunk, 1'b0));
                    erased_copy[r] = erased_copy[r] + irep_pkg::COUNT_W'(chunk);
                    cmds++;
                end
            end
        end
        planned_results.push_back(erase_result(irep_pkg::ST_DONE, '0, '0, '0, 1'b1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (bounds_copy[r])
            begin
                bounds_copy[r] = '0;
                erased_copy[r] = '0;
            end
            planned_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[irep_pkg::PADDR_W-1:3] < irep_pkg::REGIONS)
                bounds_copy[paddr[irep_pkg::PADDR_W-1:3]] = pwdata;
            if (m_tvalid && m_tready)
            begin
                if (planned_results.size() == 0)
                    report_mismatch("result with none planned", 64'(m_tdata), '0);
                else
                begin
                    head = planned_results.pop_front();
                    if (m_tuser != head.status)
                        report_mismatch("status", 64'(m_tuser), 64'(head.status));
                    if (m_tdata[irep_pkg::REGION_W-1:0] != head.region)
                        report_mismatch("region", 64'(m_tdata[irep_pkg::REGION_W-1:0]),
                                        64'(head.region));
                    if (m_tdata[irep_pkg::REGION_W +: irep_pkg::ADDR_W] != head.erase_addr)
                        report_mismatch("erase_addr",
                                        64'(m_tdata[irep_pkg::REGION_W +: irep_pkg::ADDR_W]),
                                        64'(head.erase_addr));
                    if (m_tdata[irep_pkg::REGION_W+irep_pkg::ADDR_W +: irep_pkg::SECS_W]
                        != head.erase_sectors)
                        report_mismatch("erase_sectors",
                            64'(m_tdata[irep_pkg::REGION_W+irep_pkg::ADDR_W +: irep_pkg::SECS_W]),
                            64'(head.erase_sectors));
                    if (m_tlast != head.last)
                        report_mismatch("last", 64'(m_tlast), 64'(head.last));
                end
            end
            if (s_tvalid && s_tready)
                plan_request(s_tuser, s_tdata[irep_pkg::ADDR_W-1:0],
                             s_tdata[irep_pkg::ADDR_W +: irep_pkg::WORDS_W]);
            outstanding = planned_results.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ============================================================================
// testbench - stimulus and verdict for the region erase planner
// Programs region bounds over the register port, sends directed and random
// write and clear requests under changing idle patterns and back-pressure,
// and reports the verdict from the checker's failure and outstanding counts.
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 32;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_WORDS     = 1048576;

    typedef enum int {
        SHAPE_FULL,
        SHAPE_EMPTY,
        SHAPE_REVERSED,
        SHAPE_RAGGED,
        SHAPE_SECTORS
    } shape_t;

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [irep_pkg::PADDR_W-1:0]     paddr;
    logic [irep_pkg::BOUNDS_W-1:0]    pwdata;
    logic [irep_pkg::BOUNDS_W-1:0]    prdata;
    logic                             pready;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [irep_pkg::S_TDATA_W-1:0]   s_tdata;  // start_addr, word_count
    logic                             s_tuser;  // kind
    logic                             m_tvalid;
    logic                             m_tready;
    logic [irep_pkg::M_TDATA_W-1:0]   m_tdata;  // region, erase_addr, erase_sectors
    logic [1:0]                       m_tuser;  // status
    logic                             m_tlast;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned rx_hold_left = 0;
    int unsigned quiet_cycles = 0;

    irep_pkg::bounds_vec_t plan_bounds;
    irep_pkg::bounds_vec_t cfg;

    incremental_region_erase_planner i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    erase_plan_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_bounds(input int idx, input logic [irep_pkg::BOUNDS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= irep_pkg::PADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        plan_bounds[idx] = value;
        @(posedge clk);
    endtask

    task automatic program_regions(input irep_pkg::bounds_vec_t regions);
        for (int r = 0; r < irep_pkg::REGIONS; r++)
            write_bounds(r, regions[r]);
    endtask

    task automatic send_item(input logic kind, input logic [irep_pkg::ADDR_W-1:0] addr,
                             input logic [irep_pkg::WORDS_W-1:0] words);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, words, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold the input until every planned result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [irep_pkg::BOUNDS_W-1:0] pick_bounds(input shape_t shape);
        logic [irep_pkg::ADDR_W-1:0] lo;
        logic [irep_pkg::ADDR_W-1:0] hi;
        logic [63:0]                 span;
        int unsigned                 sectors;
        int unsigned                 roll;
        case (shape)
            SHAPE_FULL:
            begin
                lo = '0;
                hi = '1;
            end
            SHAPE_EMPTY:
            begin
                lo = $urandom;
                hi = lo;
            end
            SHAPE_REVERSED:
            begin
                lo = $urandom_range(32'hFFFF_FFFF, 1);
                hi = $urandom_range(lo - 1, 0);
            end
            SHAPE_RAGGED:
            begin
                lo = $urandom_range(32'h7FFF_FFFF);
                hi = lo + $urandom_range(irep_pkg::SECTOR_BYTES - 2, 1);
            end
            default:
            begin
                roll = $urandom_range(9);
                if (roll < 6)
                    sectors = $urandom_range(16, 1);
                else if (roll < 9)
                    sectors = $urandom_range(1024, 17);
                else
                    sectors = $urandom_range(32'h3FFFF, 1025);
                span = 64'(sectors) << irep_pkg::SECTOR_SHIFT;
                lo   = $urandom_range(32'(64'h1_0000_0000 - span), 0);
                hi   = lo + 32'(span) - 32'd1;
            end
        endcase
        return {lo, hi};
    endfunction

    task automatic send_random_item();
        int unsigned                  roll;
        int unsigned                  r;
        logic [irep_pkg::ADDR_W-1:0]  lo;
        logic [irep_pkg::ADDR_W-1:0]  hi;
        logic [irep_pkg::ADDR_W-1:0]  span;
        logic [irep_pkg::ADDR_W-1:0]  offset;
        logic [irep_pkg::ADDR_W-1:0]  addr;
        logic [irep_pkg::WORDS_W-1:0] words;
        roll = $urandom_range(99);
        if (roll < 6)
            send_item(irep_pkg::KIND_CLEAR, $urandom,
                      irep_pkg::WORDS_W'($urandom_range(MAX_WORDS)));
        else if (roll < 20)
            send_item(irep_pkg::KIND_WRITE, $urandom,
                      irep_pkg::WORDS_W'($urandom_range(MAX_WORDS)));
        else
        begin
            r    = $urandom_range(irep_pkg::REGIONS - 1);
            lo   = plan_bounds[r][irep_pkg::BOUNDS_W-1:irep_pkg::ADDR_W];
            hi   = plan_bounds[r][irep_pkg::ADDR_W-1:0];
            span = (hi > lo) ? hi - lo : '0;
            if (span == '0)
                addr = $urandom;
            else
            begin
                offset = $urandom_range(span - 1);
                if ($urandom_range(1))
                    offset = offset & 32'h3FFFF;
                addr = lo + offset;
            end
            roll = $urandom_range(9);
            if (roll < 6)
                words = irep_pkg::WORDS_W'($urandom_range(8192));
            else if (roll < 9)
                words = irep_pkg::WORDS_W'($urandom_range(65536));
            else
                words = irep_pkg::WORDS_W'($urandom_range(MAX_WORDS));
            send_item(irep_pkg::KIND_WRITE, addr, words);
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tuser  <= irep_pkg::KIND_WRITE;
        s_tdata  <= '0;
        plan_bounds = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 33;
        rx_idle_pct = 88;

        // reset bounds: every region empty
        send_item(irep_pkg::KIND_WRITE, 32'h0, 21'd0);
        send_item(irep_pkg::KIND_CLEAR, 32'hFFFF_FFFF, irep_pkg::WORDS_W'(MAX_WORDS));
        drain();

        write_bounds(3, {32'h0000_0100, 32'h0000_4100});
        send_item(irep_pkg::KIND_WRITE, 32'h0000_0200, 21'd1);
        drain();
        write_bounds(3, {32'h0000_5000, 32'h0000_4FFF});
        send_item(irep_pkg::KIND_WRITE, 32'h0000_4FF0, 21'd1);
        send_item(irep_pkg::KIND_CLEAR, 32'h0, 21'd0);
        drain();

        cfg[0] = {32'h0000_0000, 32'h0003_FFFF};
        cfg[1] = {32'h0004_0000, 32'h0007_FFFF};
        cfg[2] = {32'hF000_0000, 32'hFFFF_FFFF};
        cfg[3] = {32'h0004_0000, 32'h0005_FFFF};
        cfg[4] = {32'h1234_0000, 32'h1234_0000};
        program_regions(cfg);
        send_item(irep_pkg::KIND_WRITE, 32'h0000_0000, 21'd0);
        send_item(irep_pkg::KIND_WRITE, 32'h0000_0000, 21'd1);
        send_item(irep_pkg::KIND_WRITE, 32'h0000_0100, 21'd4096);
        send_item(irep_pkg::KIND_WRITE, 32'h0000_0010, 21'd1);
        send_item(irep_pkg::KIND_WRITE, 32'h0003_FFFF, irep_pkg::WORDS_W'(MAX_WORDS));
        send_item(irep_pkg::KIND_WRITE, 32'h0004_0000, irep_pkg::WORDS_W'(MAX_WORDS));
        // repeated writes at the top address, the inclusive end of region 2, which no region matches
        repeat (5)
            send_item(irep_pkg::KIND_WRITE, 32'hFFFF_FFFF, irep_pkg::WORDS_W'(MAX_WORDS));
        send_item(irep_pkg::KIND_WRITE, 32'h1234_0000, 21'd5);
        send_item(irep_pkg::KIND_CLEAR, 32'h0, 21'd0);
        send_item(irep_pkg::KIND_WRITE, 32'h0004_0020, 21'd0);
        drain();

        cfg[0] = {32'h0000_0000, 32'hFFFF_FFFF};
        for (int r = 1; r < irep_pkg::REGIONS; r++)
            cfg[r] = '1;
        program_regions(cfg);
        send_item(irep_pkg::KIND_WRITE, 32'hFFFF_FFFF, irep_pkg::WORDS_W'(MAX_WORDS));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                tx_idle_pct = 33;
                rx_idle_pct = 88;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 88;
                rx_idle_pct = 33;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int r = 0; r < irep_pkg::REGIONS; r++)
            begin
                case ($urandom_range(9))
                    0:       cfg[r] = pick_bounds(SHAPE_FULL);
                    1:       cfg[r] = pick_bounds(SHAPE_EMPTY);
                    default: cfg[r] = pick_bounds(SHAPE_SECTORS);
                endcase
            end
            if (p == 1)
                cfg[$urandom_range(irep_pkg::REGIONS - 1)] =
                    pick_bounds($urandom_range(1) ? SHAPE_REVERSED : SHAPE_RAGGED);
            program_regions(cfg);
            if (p == 4)
                rx_hold_left = LONG_HOLD;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == PHASE_ITEMS / 2)
                    drain();
                send_random_item();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ incremental_region_erase_planner.f @@
hdl/irep_pkg.sv
hdl/irep_cfg.sv
hdl/irep_front.sv
hdl/irep_fifo.sv
hdl/irep_back.sv
hdl/incremental_region_erase_planner.sv
hdl/irep_checker.sv
tb/sv/erase_plan_checker.sv
tb/sv/testbench.sv
